// ----- rtl/frame_pacing_queue_top_assert.svh -----
// Assertion macros shared by the frame pacing queue RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk, disabled in rst.
`ifndef FRAME_PACING_QUEUE_TOP_ASSERT_SVH
`define FRAME_PACING_QUEUE_TOP_ASSERT_SVH

// Condition holds at every edge out of reset.
`define FPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define FPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fpq_pkg.sv -----
// Shared constants, codes and control structs for the frame pacing queue.
// No dependencies; imported by fpq_ctrl, fpq_dp and the top level.
package fpq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int STALL_MARGIN = 8;
  localparam int MAX_RESULTS  = 16;
  localparam int AGE_SLACK    = 2;
  localparam int HOLD_CAP     = 4;

  localparam int IDX_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int CMP_W    = $clog2(QUEUE_DEPTH + STALL_MARGIN + 16);
  localparam int N_W      = $clog2(MAX_RESULTS);
  localparam int RES_W    = 3;
  localparam int STEADY_W = 4;
  localparam int PERIOD_W = 20;
  localparam int LIMIT_W  = STEADY_W + PERIOD_W;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int TIME_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int EV_W     = 2;
  localparam int HELD_W   = 3;
  localparam int ENTRY_W  = HANDLE_W + TIME_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - HANDLE_W - HELD_W;

  localparam logic [RES_W-1:0]    RESERVE_RESET = 3'd1;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 20'd16667;

  // Result event codes
  localparam logic [EV_W-1:0] EV_DROP   = 2'd0;
  localparam logic [EV_W-1:0] EV_PICK   = 2'd1;
  localparam logic [EV_W-1:0] EV_HELD   = 2'd2;
  localparam logic [EV_W-1:0] EV_REJECT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESERVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd2;

  typedef struct packed {
    logic            in_ready;
    logic            enq;
    logic            clr_n;
    logic            pop;
    logic            emit;
    logic [EV_W-1:0] ev;
    logic            last;
  } fpq_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic full;
    logic stall;
    logic aged;
    logic more;
    logic below;
    logic out_free;
  } fpq_stat_t;

endpackage

// ----- rtl/fpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module fpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fpq_ctrl.sv -----
// Sequencing state machine for the frame pacing queue.
// Depends on fpq_pkg for command/status structs and event codes.
module fpq_ctrl
  import fpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  fpq_stat_t stat,
  output fpq_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REJECT = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_STALL  = 3'd3;
  localparam logic [2:0] ST_FINAL  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.ev     = EV_DROP;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          if (stat.in_tick) begin
            cmd.clr_n  = 1'b1;
            state_next = ST_DECIDE;
          end else if (stat.full) begin
            state_next = ST_REJECT;
          end else begin
            cmd.enq = 1'b1;
          end
        end
      end
      ST_REJECT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.ev     = EV_REJECT;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DECIDE: begin
        if (stat.stall) begin
          state_next = ST_STALL;
        end else if (stat.aged) begin
          // drop one stale head frame before the pick
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.ev     = EV_DROP;
            cmd.pop    = 1'b1;
            state_next = ST_FINAL;
          end
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_STALL: begin
        if (stat.more) begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            cmd.ev   = EV_DROP;
            cmd.pop  = 1'b1;
          end
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
          if (stat.below) begin
            cmd.ev = EV_HELD;
          end else begin
            cmd.ev  = EV_PICK;
            cmd.pop = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/fpq_dp.sv -----
// Datapath of the frame pacing queue: config registers, slot RAM, pointers,
// age check, hold counter and output register. Depends on fpq_pkg and fpq_ram.
`include "frame_pacing_queue_top_assert.svh"

module fpq_dp
  import fpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [EV_W-1:0]        m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  fpq_cmd_t               cmd,
  output fpq_stat_t              stat
);

  logic [RES_W-1:0]    reserve_depth;
  logic                flush_mode;
  logic [PERIOD_W-1:0] refresh_period;

  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    head_next;
  logic [CNT_W-1:0]    count;
  logic [SUM_W-1:0]    tail_sum;
  logic [IDX_W-1:0]    tail;
  logic [N_W-1:0]      n_drop;
  logic [HELD_W-1:0]   hold_count;
  logic [HELD_W-1:0]   held_sat;
  logic [LIMIT_W-1:0]  limit;
  logic [TIME_W-1:0]   time_lat;
  logic [HANDLE_W-1:0] handle_lat;
  logic [ENTRY_W-1:0]  rd_entry;
  logic [TIME_W-1:0]   age;
  logic [STEADY_W-1:0] steady;
  logic                take;
  logic                over;

  logic                o_valid;
  logic [EV_W-1:0]     o_ev;
  logic [HANDLE_W-1:0] o_handle;
  logic [HELD_W-1:0]   o_held;
  logic                o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserve_depth  <= RESERVE_RESET;
      flush_mode     <= 1'b0;
      refresh_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESERVE: reserve_depth  <= cfg_data[RES_W-1:0];
        REG_FLUSH:   flush_mode     <= cfg_data[0];
        REG_PERIOD:  refresh_period <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Age threshold in microseconds, registered ahead of the compare
  always_ff @(posedge clk) begin
    limit <= (STEADY_W'(reserve_depth) + STEADY_W'(AGE_SLACK)) * LIMIT_W'(refresh_period);
  end

  assign take   = s_axis_tvalid && cmd.in_ready;
  assign steady = flush_mode ? STEADY_W'(1) : STEADY_W'(reserve_depth) + STEADY_W'(1);

  always_ff @(posedge clk) begin
    if (take) begin
      time_lat   <= s_axis_tdata[TIME_W-1:0];
      handle_lat <= s_axis_tdata[TIME_W +: HANDLE_W];
    end
  end

  assign head_next = !cmd.pop ? head :
                     (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum  = SUM_W'(head) + SUM_W'(count);
  assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      n_drop <= '0;
    end else begin
      head <= head_next;
      if (cmd.enq) begin
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        count <= count - 1'b1;
      end
      if (cmd.clr_n) begin
        n_drop <= '0;
      end else if (cmd.pop) begin
        n_drop <= n_drop + 1'b1;
      end
    end
  end

  // Read at the next head so the registered read data holds the current head entry
  fpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.enq),
    .waddr (tail),
    .wdata ({s_axis_tdata[TIME_W +: HANDLE_W], s_axis_tdata[TIME_W-1:0]}),
    .raddr (head_next),
    .rdata (rd_entry)
  );

  assign age  = time_lat - rd_entry[TIME_W-1:0];
  assign over = count > CNT_W'(steady);

  assign stat.in_valid = s_axis_tvalid;
  assign stat.in_tick  = s_axis_tuser;
  assign stat.full     = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.stall    = CMP_W'(count) >= (CMP_W'(steady) + CMP_W'(STALL_MARGIN));
  assign stat.aged     = over && (age > TIME_W'(limit));
  assign stat.more     = over && (n_drop < N_W'(MAX_RESULTS - 1));
  assign stat.below    = count < CNT_W'(steady);
  assign stat.out_free = !o_valid || m_axis_tready;

  assign held_sat = (hold_count > HELD_W'(HOLD_CAP)) ? HELD_W'(HOLD_CAP) : hold_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
    end else if (cmd.emit && cmd.ev == EV_PICK) begin
      hold_count <= HELD_W'(1);
    end else if (cmd.emit && cmd.ev == EV_HELD) begin
      if (hold_count != '0 && hold_count < HELD_W'(HOLD_CAP)) begin
        hold_count <= hold_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.emit) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_ev   <= cmd.ev;
      o_last <= cmd.last;
      o_held <= (cmd.ev == EV_PICK) ? held_sat : '0;
      case (cmd.ev)
        EV_REJECT: o_handle <= handle_lat;
        EV_HELD:   o_handle <= '0;
        default:   o_handle <= rd_entry[ENTRY_W-1:TIME_W];
      endcase
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {OUT_PAD_W'(0), o_held, o_handle};
  assign m_axis_tuser  = o_ev;
  assign m_axis_tlast  = o_last;

  `FPQ_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `FPQ_ASSERT_ALWAYS(a_pop_nonempty, !cmd.pop || count != '0, "pop from empty queue")
  `FPQ_ASSERT_ALWAYS(a_emit_free, !cmd.emit || !o_valid || m_axis_tready, "result overwritten")
  `FPQ_ASSERT_NEXT(a_pick_hold, cmd.emit && cmd.ev == EV_PICK, hold_count == HELD_W'(1), "hold not reset on pick")

endmodule

// ----- rtl/frame_pacing_queue_top.sv -----
// Top level of the frame pacing queue: controller plus datapath.
// Depends on fpq_pkg, fpq_ctrl, fpq_dp and fpq_ram.

// Frame pacing queue. Frame-ready transactions (tuser 0) enqueue a handle and
// its arrival time and produce no result. When the queue is full they produce
// one reject result instead, and the input stays blocked until that result is
// loaded into the output register. Refresh-tick transactions pass a decide
// state that checks depth and age and may drop one stale frame, then a final
// state that emits the pick or held result with tlast, then return to idle.
// A stall flush drops up to fifteen frames at one per cycle while the output
// register is free, before the final pick or held result. The slot memory
// read is registered and is issued at the next head, so the head entry is
// ready when the tick is checked. Output back-pressure stalls every step that
// emits a result. The next transaction is accepted in the cycle after the final
// result is loaded into the output register. Configuration writes must be
// issued while the block is idle.
module frame_pacing_queue_top
  import fpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // time_us[31:0], frame_handle[47:32]
  input  logic                   s_axis_tuser,  // kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // handle_out[15:0], held_refreshes[18:16], zero
  output logic [EV_W-1:0]        m_axis_tuser,  // event_res
  output logic                   m_axis_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  fpq_cmd_t  cmd;
  fpq_stat_t stat;

  fpq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  fpq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

// ----- verif/fpq_tb_pkg.sv -----
// Item kind codes shared by the frame pacing queue testbench files.
// No dependencies; imported by the checker and the testbench top.
package fpq_tb_pkg;

  localparam logic KIND_FRAME = 1'b0;  // frame ready, enqueue
  localparam logic KIND_TICK  = 1'b1;  // display refresh tick

endpackage

// ----- verif/fpq_pacing_checker.sv -----
// Result checker for the frame pacing queue: follows the config port and both stream
// channels, predicts the result stream and compares it. Depends on fpq_pkg, fpq_tb_pkg.
module fpq_pacing_checker
  import fpq_pkg::*, fpq_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // time_us[31:0], frame_handle[47:32]
  input  logic                   s_axis_tuser,  // kind
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // handle_out[15:0], held_refreshes[18:16], zero
  input  logic [EV_W-1:0]        m_axis_tuser,  // event_res
  input  logic                   m_axis_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     fail_count,
  output int                     pending_count
);

  typedef struct packed {
    logic [EV_W-1:0]     ev;
    logic [HANDLE_W-1:0] handle;
    logic [HELD_W-1:0]   held;
    logic                last;
  } pace_result_t;

  pace_result_t pace_results_q [$];

  // Shadow of the block: frame FIFO, pick history and registers
  logic [HANDLE_W-1:0] queue_handle [QUEUE_DEPTH];
  logic [TIME_W-1:0]   queue_time   [QUEUE_DEPTH];
  logic [IDX_W-1:0]    head;
  logic [CNT_W-1:0]    depth;
  logic [HELD_W-1:0]   since_pick;
  logic [RES_W-1:0]    reserve;
  logic                flush;
  logic [PERIOD_W-1:0] period;

  function automatic void expect_result(input logic [EV_W-1:0] ev,
                                        input logic [HANDLE_W-1:0] h,
                                        input logic [HELD_W-1:0] held,
                                        input logic lst);
    pace_result_t r;
    r.ev     = ev;
    r.handle = h;
    r.held   = held;
    r.last   = lst;
    pace_results_q = {pace_results_q, r};
  endfunction

  function automatic logic [HANDLE_W-1:0] pop_oldest();
    logic [HANDLE_W-1:0] h;
    h = queue_handle[head];
    head++;
    depth--;
    return h;
  endfunction

  function automatic void predict_frame(input logic [TIME_W-1:0] now,
                                        input logic [HANDLE_W-1:0] h);
    logic [IDX_W-1:0] tail;
    if (int'(depth) >= QUEUE_DEPTH) begin
      expect_result(EV_REJECT, h, '0, 1'b1);
    end else begin
      tail = head + depth[IDX_W-1:0];
      queue_handle[tail] = h;
      queue_time[tail]   = now;
      depth++;
    end
  endfunction

  function automatic void predict_refresh(input logic [TIME_W-1:0] now);
    int                steady_depth;
    int                drops;
    logic [TIME_W-1:0] age;
    logic [63:0]       age_limit;
    steady_depth = flush ? 1 : 1 + int'(reserve);
    drops = 0;
    if (int'(depth) >= steady_depth + STALL_MARGIN) begin
      // Stall: flush down to steady depth, leaving room for the pick or held result
      while (int'(depth) > steady_depth && drops < MAX_RESULTS - 1) begin
        expect_result(EV_DROP, pop_oldest(), '0, 1'b0);
        drops++;
      end
    end else if (int'(depth) > steady_depth) begin
      // Age rule uses the reserve even when flushing; age wraps modulo 2^32
      age = now - queue_time[head];
      age_limit = (64'(reserve) + 64'(AGE_SLACK)) * 64'(period);
      if (64'(age) > age_limit) expect_result(EV_DROP, pop_oldest(), '0, 1'b0);
    end
    if (int'(depth) < steady_depth) begin
      if (since_pick != 0 && since_pick < HOLD_CAP) since_pick++;
      expect_result(EV_HELD, '0, '0, 1'b1);
    end else begin
      expect_result(EV_PICK, pop_oldest(),
                    (since_pick > HOLD_CAP) ? HELD_W'(HOLD_CAP) : since_pick, 1'b1);
      since_pick = 1;
    end
  endfunction

  always @(posedge clk) begin : watch
    pace_result_t             want;
    logic [OUT_TDATA_W-1:0]   want_data;
    if (rst) begin
      pace_results_q.delete();
      fail_count = 0;
      head       = '0;
      depth      = '0;
      since_pick = '0;
      reserve    = RESERVE_RESET;
      flush      = 1'b0;
      period     = PERIOD_RESET;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pace_results_q.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected result: ev %0d tdata %h last %b",
                     $realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want = pace_results_q[0];
          pace_results_q.delete(0);
          want_data = {OUT_PAD_W'(0), want.held, want.handle};
          if (m_axis_tuser !== want.ev || m_axis_tdata !== want_data ||
              m_axis_tlast !== want.last) begin
            if (fail_count < 10)
              $display("[%0t] mismatch: expected ev %0d tdata %h last %b, got ev %0d tdata %h last %b",
                       $realtime, want.ev, want_data, want.last,
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RESERVE: reserve = cfg_data[RES_W-1:0];
          REG_FLUSH:   flush   = cfg_data[0];
          REG_PERIOD:  period  = cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KIND_FRAME)
          predict_frame(s_axis_tdata[TIME_W-1:0], s_axis_tdata[TIME_W +: HANDLE_W]);
        else
          predict_refresh(s_axis_tdata[TIME_W-1:0]);
      end
    end
    pending_count = pace_results_q.size();
  end

endmodule

// ----- verif/frame_pacing_queue_top_tb.sv -----
// Testbench top for frame_pacing_queue_top: clock, reset, stimulus, receiver and verdict.
// Depends on fpq_pkg, fpq_tb_pkg, fpq_pacing_checker and the block RTL.
module frame_pacing_queue_top_tb;
  import fpq_pkg::*, fpq_tb_pkg::*;

  localparam int N_PHASES        = 7;
  localparam int PHASE_ITEMS     = 68;
  localparam int PRESSURE_PHASE  = 1;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 1000000;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [EV_W-1:0]        m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int burst_left  = 0;
  logic hold_req  = 1'b0;

  // Per-phase register settings and share of frame-ready items (percent)
  int phase_reserve [N_PHASES] = '{0, 7, 3, 7, 2, 5, 0};
  int phase_flush   [N_PHASES] = '{0, 0, 1, 1, 0, 0, 1};
  int phase_period  [N_PHASES] = '{1, 1000000, 1048575, 0, 16667, 250, 1};
  int phase_frames  [N_PHASES] = '{50, 85, 55, 50, 70, 40, 65};

  frame_pacing_queue_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  fpq_pacing_checker pacing_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** frame_pacing_queue_top: FAILED **");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic k, input logic [TIME_W-1:0] t,
                           input logic [HANDLE_W-1:0] h);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {h, t};
    burst_left--;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending, wait for every expected result, then let the block go idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input int r, input int f, input int per);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RESERVE;
    cfg_data  <= CFG_W'(r);
    @(negedge clk);
    cfg_index <= REG_FLUSH;
    cfg_data  <= CFG_W'(f);
    @(negedge clk);
    cfg_index <= REG_PERIOD;
    cfg_data  <= CFG_W'(per);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: changing ready patterns, plus one long hold-off on request
  initial begin
    int   mode;
    int   left;
    logic hold_taken;
    mode = 0;
    left = 0;
    hold_taken = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 150);
      end
      left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= ((left % 8) < 5);
      endcase
    end
  end

  initial begin
    logic [TIME_W-1:0] now_us;
    int                step_max;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_FRAME;
    cfg_we        = 1'b0;
    cfg_index     = REG_RESERVE;
    cfg_data      = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under reset settings: steady depth 2, age limit 50001
    send_item(KIND_TICK, 32'd5, 16'h0000);             // empty: held, no pick yet
    send_item(KIND_FRAME, 32'hFFFF_FFF0, 16'hFFFF);
    send_item(KIND_FRAME, 32'hFFFF_FFFF, 16'h0000);
    send_item(KIND_TICK, 32'h0000_0010, 16'hFFFF);     // first pick
    for (int i = 0; i < 4; i++)
      send_item(KIND_TICK, 32'd20 + 32'(i), 16'h0000);  // held, count saturates
    send_item(KIND_FRAME, 32'd100, 16'h1234);
    send_item(KIND_FRAME, 32'd200, 16'hABCD);
    send_item(KIND_TICK, 32'd50000, 16'h0000);         // age equals limit across wrap
    send_item(KIND_FRAME, 32'd300, 16'h8001);
    send_item(KIND_TICK, 32'd50102, 16'h0000);         // age over limit: drop one
    for (int i = 0; i < 15; i++)
      send_item(KIND_FRAME, 32'd60000 + 32'(i), (i % 2) ? 16'hAAAA : 16'h5555);
    send_item(KIND_FRAME, 32'd61000, 16'hFFFF);        // full: reject
    send_item(KIND_TICK, 32'd61001, 16'h0000);         // stall flush

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      write_config(phase_reserve[p], phase_flush[p], phase_period[p]);
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      now_us = $urandom;
      step_max = (phase_period[p] == 0) ? 4 : 2 * phase_period[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Mostly steady time progress, sometimes a jump to anywhere
        if ($urandom_range(0, 19) == 0)
          now_us = $urandom;
        else
          now_us = now_us + TIME_W'($urandom_range(0, step_max));
        send_item(($urandom_range(0, 99) < phase_frames[p]) ? KIND_FRAME : KIND_TICK,
                  now_us, HANDLE_W'($urandom));
      end
    end

    settle();
    if (fail_count == 0)
      $display("** frame_pacing_queue_top: PASSED **");
    else
      $display("** frame_pacing_queue_top: FAILED **");
    $finish;
  end

endmodule
